// ----- hw/rtl/jsu_pkg.sv -----
// ============================================================================
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Holds the escape phase encoding, status codes, the command record that
// the front end hands to the back end, and the UTF-8 byte encoder.
// ============================================================================
`default_nettype none

package jsu_pkg;

    // Default width of the decoded byte counter.
    localparam int COUNT_WIDTH_DEF = 16;
    // Default depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration port geometry.
    localparam int ADDR_W           = 3;
    localparam int REG_OUT_CAPACITY = 0;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // UTF-8 lead and continuation markers.
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TOO_SMALL = 2'd2
    } status_t;

    // Escape parser phases.
    typedef enum logic [3:0] {
        PH_NORMAL  = 4'd0,
        PH_ESC     = 4'd1,
        PH_HI_0    = 4'd2,
        PH_HI_1    = 4'd3,
        PH_HI_2    = 4'd4,
        PH_HI_3    = 4'd5,
        PH_WANT_BS = 4'd6,
        PH_WANT_U  = 4'd7,
        PH_LO_0    = 4'd8,
        PH_LO_1    = 4'd9,
        PH_LO_2    = 4'd10,
        PH_LO_3    = 4'd11
    } phase_t;

    // One queued command: a byte sequence of seq_len bytes, optionally
    // followed by the string close record.
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  seq_len;
        logic        done;
        status_t     status;
        logic [15:0] length;
    } cmd_t;

    // Byte k of a sequence of length n. A length of one sends the low byte
    // as it is, which also covers raw pass-through bytes.
    function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] n,
                                             logic [1:0] k);
        logic [7:0] b;
        b = cp[7:0];
        case (n)
            3'd2: begin
                case (k)
                    2'd0:    b = UTF8_LEAD2 | {3'b000, cp[10:6]};
                    default: b = UTF8_CONT | {2'b00, cp[5:0]};
                endcase
            end
            3'd3: begin
                case (k)
                    2'd0:    b = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    b = UTF8_CONT | {2'b00, cp[11:6]};
                    default: b = UTF8_CONT | {2'b00, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (k)
                    2'd0:    b = UTF8_LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    b = UTF8_CONT | {2'b00, cp[17:12]};
                    2'd2:    b = UTF8_CONT | {2'b00, cp[11:6]};
                    default: b = UTF8_CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_front.sv -----
// ============================================================================
// jsu_front: escape parser and capacity check
// Accepts up to one input request per cycle, runs the escape state machine,
// checks the output budget and writes one command per productive request.
// ============================================================================
`default_nettype none

module jsu_front #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_take,
    input  wire logic [7:0]   in_byte,
    input  wire logic         has_byte,
    input  wire logic         end_of_string,
    input  wire logic [15:0]  out_capacity,
    output logic              cmd_push,
    output jsu_pkg::cmd_t     cmd
);
    import jsu_pkg::*;

    localparam int CMPW = (COUNT_WIDTH >= 16) ? COUNT_WIDTH + 1 : 17;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Hex digit decode: bit 4 is the valid flag.
    function automatic logic [4:0] hex_digit(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // Encoded length of a basic-plane code point.
    function automatic logic [2:0] utf8_len(logic [15:0] cp);
        logic [2:0] n;
        if (cp <= 16'h007F) begin
            n = 3'd1;
        end else if (cp <= 16'h07FF) begin
            n = 3'd2;
        end else begin
            n = 3'd3;
        end
        return n;
    endfunction

    phase_t                   phase_reg, phase_next, phase_byte;
    logic [15:0]              hex_reg, hex_next;
    logic [9:0]               hh_reg, hh_next;
    logic [COUNT_WIDTH-1:0]   bw_reg, bw_next, bw_after;
    status_t                  err_reg, err_next, err_after, done_status;

    logic                     take, done_take;
    logic [4:0]               dig;
    logic [15:0]              hex_shift;
    logic                     hi_range, lo_range;
    logic                     fmt_err, emit_req, emit_ok;
    logic [2:0]               emit_n, need;
    logic [20:0]              emit_cp;
    logic [CMPW-1:0]          sum_w, cap_w, bw_ext;
    logic                     cap_ge, ovf;

    // Request decode and shared digit logic.
    assign take      = item_take && has_byte && (err_reg == ST_OK);
    assign done_take = item_take && end_of_string;
    assign dig       = hex_digit(in_byte);
    assign hex_shift = {hex_reg[11:0], dig[3:0]};
    assign hi_range  = (hex_shift >= 16'hD800) && (hex_shift <= 16'hDBFF);
    assign lo_range  = (hex_shift >= 16'hDC00) && (hex_shift <= 16'hDFFF);

    // Next phase of the escape parser.
    always_comb
    begin
        phase_byte = phase_reg;
        if (take) begin
            case (phase_reg)
                PH_NORMAL: begin
                    if (in_byte == CH_BSL) phase_byte = PH_ESC;
                end
                PH_ESC: begin
                    phase_byte = (in_byte == CH_U) ? PH_HI_0 : PH_NORMAL;
                end
                PH_HI_0: if (dig[4]) phase_byte = PH_HI_1;
                PH_HI_1: if (dig[4]) phase_byte = PH_HI_2;
                PH_HI_2: if (dig[4]) phase_byte = PH_HI_3;
                PH_HI_3: begin
                    if (dig[4]) begin
                        phase_byte = (hi_range || lo_range) ? PH_WANT_BS : PH_NORMAL;
                    end
                end
                PH_WANT_BS: if (in_byte == CH_BSL) phase_byte = PH_WANT_U;
                PH_WANT_U:  if (in_byte == CH_U) phase_byte = PH_LO_0;
                PH_LO_0: if (dig[4]) phase_byte = PH_LO_1;
                PH_LO_1: if (dig[4]) phase_byte = PH_LO_2;
                PH_LO_2: if (dig[4]) phase_byte = PH_LO_3;
                PH_LO_3: if (dig[4] && lo_range) phase_byte = PH_NORMAL;
                default: phase_byte = phase_reg;
            endcase
        end
        phase_next = done_take ? PH_NORMAL : phase_byte;
    end

    // Parser outputs: emitted sequence, digit accumulation, format errors.
    always_comb
    begin
        fmt_err  = 1'b0;
        emit_req = 1'b0;
        emit_n   = 3'd0;
        emit_cp  = 21'd0;
        hex_next = hex_reg;
        hh_next  = hh_reg;
        if (take) begin
            case (phase_reg)
                PH_NORMAL: begin
                    if (in_byte != CH_BSL) begin
                        emit_req = 1'b1;
                        emit_n   = 3'd1;
                        emit_cp  = {13'd0, in_byte};
                    end
                end
                PH_ESC: begin
                    emit_req = 1'b1;
                    emit_n   = 3'd1;
                    case (in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: emit_cp = {13'd0, in_byte};
                        CH_B: emit_cp = 21'h08;
                        CH_F: emit_cp = 21'h0C;
                        CH_N: emit_cp = 21'h0A;
                        CH_R: emit_cp = 21'h0D;
                        CH_T: emit_cp = 21'h09;
                        CH_U: begin
                            emit_req = 1'b0;
                            hex_next = 16'd0;
                        end
                        default: begin
                            emit_req = 1'b0;
                            fmt_err  = 1'b1;
                        end
                    endcase
                end
                PH_HI_0, PH_HI_1, PH_HI_2, PH_LO_0, PH_LO_1, PH_LO_2: begin
                    if (dig[4]) hex_next = hex_shift;
                    else        fmt_err  = 1'b1;
                end
                PH_HI_3: begin
                    if (!dig[4]) begin
                        fmt_err = 1'b1;
                    end else begin
                        hex_next = hex_shift;
                        if (hi_range) begin
                            hh_next = hex_shift[9:0];
                        end else if (lo_range) begin
                            fmt_err = 1'b1;
                        end else begin
                            emit_req = 1'b1;
                            emit_n   = utf8_len(hex_shift);
                            emit_cp  = {5'd0, hex_shift};
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (in_byte != CH_BSL) fmt_err = 1'b1;
                end
                PH_WANT_U: begin
                    if (in_byte == CH_U) hex_next = 16'd0;
                    else                 fmt_err  = 1'b1;
                end
                PH_LO_3: begin
                    if (!dig[4]) begin
                        fmt_err = 1'b1;
                    end else begin
                        hex_next = hex_shift;
                        if (lo_range) begin
                            emit_req = 1'b1;
                            emit_n   = 3'd4;
                            emit_cp  = 21'h10000 + {1'b0, hh_reg, hex_shift[9:0]};
                        end else begin
                            fmt_err = 1'b1;
                        end
                    end
                end
                default: fmt_err = 1'b1;
            endcase
        end
    end

    // Output budget: a sequence fits if written + n + 1 <= capacity and the
    // counter does not pass its maximum.
    assign need    = emit_req ? emit_n : 3'd0;
    assign sum_w   = CMPW'(bw_reg) + CMPW'(need);
    assign cap_w   = CMPW'(out_capacity);
    assign cap_ge  = (sum_w >= cap_w);
    assign ovf     = (sum_w > CMPW'({COUNT_WIDTH{1'b1}}));
    assign emit_ok = emit_req && !cap_ge && !ovf;

    // Error, count and close status after this request.
    always_comb
    begin
        if (fmt_err) begin
            err_after = ST_MALFORMED;
        end else if (emit_req && !emit_ok) begin
            err_after = ST_TOO_SMALL;
        end else begin
            err_after = err_reg;
        end
        bw_after = emit_ok ? sum_w[COUNT_WIDTH-1:0] : bw_reg;

        if (err_after != ST_OK) begin
            done_status = err_after;
        end else if (phase_byte != PH_NORMAL) begin
            done_status = ST_MALFORMED;
        end else if (!emit_req && cap_ge) begin
            done_status = ST_TOO_SMALL;
        end else begin
            done_status = ST_OK;
        end

        err_next = done_take ? ST_OK : err_after;
        bw_next  = done_take ? '0 : bw_after;
    end

    // Command to the queue.
    assign bw_ext         = CMPW'(bw_after);
    assign cmd_push       = emit_ok || done_take;
    assign cmd.code_point = emit_cp;
    assign cmd.seq_len    = emit_ok ? emit_n : 3'd0;
    assign cmd.done       = done_take;
    assign cmd.status     = done_status;
    assign cmd.length     = bw_ext[15:0];

    // Per-string state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_NORMAL;
            hex_reg   <= 16'd0;
            hh_reg    <= 10'd0;
            bw_reg    <= '0;
            err_reg   <= ST_OK;
        end else if (item_take) begin
            phase_reg <= phase_next;
            hex_reg   <= done_take ? 16'd0 : hex_next;
            hh_reg    <= done_take ? 10'd0 : hh_next;
            bw_reg    <= bw_next;
            err_reg   <= err_next;
        end
    end

    // A closed string leaves the per-string state cleared.
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done_take |=> (phase_reg == PH_NORMAL) && (err_reg == ST_OK) && (bw_reg == '0))
        else $error("string close did not clear the parser state");

    // The first error sticks until the string ends.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && !end_of_string && (err_reg != ST_OK) |=> err_reg == $past(err_reg))
        else $error("error code changed before the string end");

    // Without an accepted request the parser holds its state.
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_take |=> $stable(bw_reg) && $stable(phase_reg) && $stable(err_reg))
        else $error("parser state moved without a request");

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_queue.sv -----
// ============================================================================
// jsu_queue: command queue between front and back end
// A small first-in first-out buffer of command records so that the parser
// and the byte sequencer stall independently.
// ============================================================================
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire jsu_pkg::cmd_t  wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output jsu_pkg::cmd_t       rd_data,
    output logic                rd_valid
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_back.sv -----
// ============================================================================
// jsu_back: UTF-8 byte sequencer and result register
// Walks the head command one result per cycle unless the sink stalls:
// encoded bytes first, then the close record, into the output register.
// ============================================================================
`default_nettype none

module jsu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire jsu_pkg::cmd_t  head,
    input  wire logic           head_valid,
    output logic                head_pop,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                string_done,
    output logic [1:0]          status,
    output logic [15:0]         total_length
);
    import jsu_pkg::*;

    logic [2:0]   idx_reg, idx_next;
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   byte_reg;
    logic         bv_reg, done_reg;
    status_t      status_reg;
    logic [15:0]  len_reg;

    logic         load, is_byte, last, taken;

    // Sequencing of the head command.
    assign taken    = pop && out_valid_reg;
    assign load     = head_valid && (!out_valid_reg || taken);
    assign is_byte  = (idx_reg < head.seq_len);
    assign last     = is_byte ? ((idx_reg + 3'd1 == head.seq_len) && !head.done) : 1'b1;
    assign head_pop = load && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end
        if (load) begin
            out_valid_next = 1'b1;
        end else if (taken) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg   <= is_byte ? utf8_byte(head.code_point, head.seq_len, idx_reg[1:0])
                                  : 8'd0;
            bv_reg     <= is_byte;
            done_reg   <= !is_byte;
            status_reg <= is_byte ? ST_OK : head.status;
            len_reg    <= is_byte ? 16'd0 : head.length;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = byte_reg;
    assign byte_valid   = bv_reg;
    assign string_done  = done_reg;
    assign status       = 2'(status_reg);
    assign total_length = len_reg;

    // The sequencer reaches the end of the bytes only on a closing command.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && (idx_reg >= head.seq_len) |-> head.done)
        else $error("byte index ran past a sequence without a close record");

    // Every queued command produces at least one result.
    a_no_empty_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && (head.seq_len == 3'd0) |-> head.done)
        else $error("queued command carries no result");

    // A result that does not end its command advances the byte index by one.
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        load && !head_pop |=> idx_reg == $past(idx_reg) + 3'd1)
        else $error("byte index did not advance");

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8_core.sv -----
// Flow: the edge that accepts a request writes its command into the queue;
// the result register loads from the queue head whenever it is free.
// Throughput: one input request per cycle while the command queue has room;
// one result per cycle leaves the result register while the sink pops, and a
// request that yields k results holds the byte sequencer until all are loaded.
// Reset: asynchronous, clears the parser, queue and result valid flag; the
// capacity register returns to 65535.
// ============================================================================
// json_string_unescape_utf8_core: JSON string body unescaper with UTF-8 out
// Top level: configuration register, parser front end, command queue and
// byte sequencer back end.
// ============================================================================
`default_nettype none

module json_string_unescape_utf8_core #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [7:0]                  in_byte,
    input  wire logic                        has_byte,
    input  wire logic                        end_of_string,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [7:0]                       out_byte,
    output logic                             byte_valid,
    output logic                             string_done,
    output logic [1:0]                       status,
    output logic [15:0]                      total_length,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jsu_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import jsu_pkg::*;

    localparam int REG_W = ADDR_W - 2;

    logic [15:0]  cap_reg;
    logic         cfg_wr, cap_sel;
    logic         item_take;
    logic         cmd_push, q_full, head_valid, head_pop;
    cmd_t         cmd, head;

    // Configuration register.
    assign pready  = 1'b1;
    assign cap_sel = (paddr[ADDR_W-1:2] == REG_W'(REG_OUT_CAPACITY));
    assign cfg_wr  = psel && penable && pwrite && cap_sel;
    assign prdata  = cap_sel ? {16'd0, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= CAPACITY_RESET;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[15:0];
        end
    end

    // Input acceptance.
    assign full      = q_full;
    assign item_take = push && !q_full;

    jsu_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_take     (item_take),
        .in_byte       (in_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .out_capacity  (cap_reg),
        .cmd_push      (cmd_push),
        .cmd           (cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd),
        .full     (q_full),
        .rd_en    (head_pop),
        .rd_data  (head),
        .rd_valid (head_valid)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .string_done  (string_done),
        .status       (status),
        .total_length (total_length)
    );

endmodule

`default_nettype wire

// ----- bench/json_string_unescape_utf8_core_tb.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds escaped string bodies through the request queue and checks every
// decoded byte and every closing status against a cycle-free predictor.
// ----------------------------------------------------------------------------

module json_string_unescape_utf8_core_tb;

    import jsu_pkg::*;

    // ASCII codes the escape parser reacts to.
    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] QUOTE     = 8'h22;
    localparam logic [7:0] SLASH     = 8'h2F;
    localparam logic [7:0] U_LETTER  = 8'h75;

    // Surrogate ranges of UTF-16.
    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;

    localparam int unsigned COUNT_MAX     = 65535;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 30;
    localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * REG_OUT_CAPACITY);

    // One decoded result as the block presents it.
    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic        done;
        status_t     st;
        logic [15:0] len;
    } decoded_t;

    // One row of the directed table; a closing row may carry its result.
    typedef struct packed {
        logic [7:0]  data;
        logic        has;
        logic        last;
        logic        typed;
        status_t     st;
        logic [15:0] len;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 28;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00,     1'b0, 1'b1, 1'b1, ST_OK,        16'd0},
        '{8'h00,     1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{8'hFF,     1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{8'h41,     1'b0, 1'b0, 1'b0, ST_OK,        16'd0},
        '{BACKSLASH, 1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"t",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{8'h00,     1'b0, 1'b1, 1'b1, ST_OK,        16'd3},
        '{BACKSLASH, 1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{U_LETTER,  1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"D",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"8",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"3",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"d",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{BACKSLASH, 1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{U_LETTER,  1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"d",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"E",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"0",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"0",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{8'h00,     1'b0, 1'b1, 1'b1, ST_OK,        16'd4},
        '{BACKSLASH, 1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{U_LETTER,  1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"D",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"C",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"0",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"0",       1'b1, 1'b0, 1'b0, ST_OK,        16'd0},
        '{"A",       1'b1, 1'b1, 1'b1, ST_MALFORMED, 16'd0},
        '{BACKSLASH, 1'b1, 1'b1, 1'b1, ST_MALFORMED, 16'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  in_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        end_of_string = 1'b0;
    logic        pop = 1'b0;
    logic        empty;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        string_done;
    logic [1:0]  status;
    logic [15:0] total_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Decoder mirror: per-string parser state plus the capacity register.
    phase_t      parse_phase;
    logic [15:0] hex_acc;
    logic [9:0]  high_bits;
    int unsigned bytes_out;
    status_t     first_fault;
    logic [15:0] capacity;

    decoded_t    pending_bytes [$];
    logic [7:0]  body [$];
    int          fail_count = 0;
    int          item_count = 0;
    int          quiet_cycles = 0;
    int          pop_run = 0;
    logic        pop_level = 1'b0;
    bit          no_gaps = 1'b0;

    json_string_unescape_utf8_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .string_done   (string_done),
        .status        (status),
        .total_length  (total_length),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Value of an ASCII hex digit, or -1 when the byte is not one.
    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // A sequence goes out whole or not at all, keeping a terminator slot free.
    task automatic emit_seq(logic [7:0] seq [4], int n);
        if (bytes_out + n + 1 > capacity || bytes_out + n > COUNT_MAX) begin
            first_fault = ST_TOO_SMALL;
        end
        else begin
            for (int i = 0; i < n; i++)
                pending_bytes.push_back('{seq[i], 1'b1, 1'b0, ST_OK, 16'd0});
            bytes_out += n;
        end
    endtask

    task automatic emit_one(logic [7:0] b);
        logic [7:0] seq [4];
        seq = '{b, 8'h00, 8'h00, 8'h00};
        emit_seq(seq, 1);
    endtask

    // UTF-8 encoding of one code point.
    task automatic emit_code_point(logic [20:0] cp);
        logic [7:0] seq [4];
        int n;
        if (cp <= 21'h7F) begin
            seq = '{cp[7:0], 8'h00, 8'h00, 8'h00};
            n = 1;
        end
        else if (cp <= 21'h7FF) begin
            seq = '{8'hC0 | cp[10:6], 8'h80 | cp[5:0], 8'h00, 8'h00};
            n = 2;
        end
        else if (cp <= 21'hFFFF) begin
            seq = '{8'hE0 | cp[15:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0], 8'h00};
            n = 3;
        end
        else begin
            seq = '{8'hF0 | cp[20:18], 8'h80 | cp[17:12], 8'h80 | cp[11:6],
                    8'h80 | cp[5:0]};
            n = 4;
        end
        emit_seq(seq, n);
    endtask

    // Advances the escape parser by one raw byte.
    task automatic decode_byte(logic [7:0] b);
        int d;
        d = hex_digit(b);
        case (parse_phase)
            PH_NORMAL: begin
                if (b == BACKSLASH) parse_phase = PH_ESC;
                else emit_one(b);
            end
            PH_ESC: begin
                parse_phase = PH_NORMAL;
                case (b)
                    QUOTE, BACKSLASH, SLASH: emit_one(b);
                    "b": emit_one(8'h08);
                    "f": emit_one(8'h0C);
                    "n": emit_one(8'h0A);
                    "r": emit_one(8'h0D);
                    "t": emit_one(8'h09);
                    U_LETTER: begin
                        hex_acc = 16'h0;
                        parse_phase = PH_HI_0;
                    end
                    default: first_fault = ST_MALFORMED;
                endcase
            end
            PH_HI_0, PH_HI_1, PH_HI_2, PH_HI_3: begin
                if (d < 0) begin
                    first_fault = ST_MALFORMED;
                end
                else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (parse_phase != PH_HI_3) begin
                        parse_phase = phase_t'(parse_phase + 1);
                    end
                    else if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
                        high_bits = hex_acc[9:0];
                        parse_phase = PH_WANT_BS;
                    end
                    else if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) begin
                        first_fault = ST_MALFORMED;
                    end
                    else begin
                        parse_phase = PH_NORMAL;
                        emit_code_point({5'd0, hex_acc});
                    end
                end
            end
            PH_WANT_BS: begin
                if (b == BACKSLASH) parse_phase = PH_WANT_U;
                else first_fault = ST_MALFORMED;
            end
            PH_WANT_U: begin
                if (b == U_LETTER) begin
                    hex_acc = 16'h0;
                    parse_phase = PH_LO_0;
                end
                else begin
                    first_fault = ST_MALFORMED;
                end
            end
            PH_LO_0, PH_LO_1, PH_LO_2, PH_LO_3: begin
                if (d < 0) begin
                    first_fault = ST_MALFORMED;
                end
                else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (parse_phase != PH_LO_3) begin
                        parse_phase = phase_t'(parse_phase + 1);
                    end
                    else if (hex_acc < LO_SURR_MIN || hex_acc > LO_SURR_MAX) begin
                        first_fault = ST_MALFORMED;
                    end
                    else begin
                        parse_phase = PH_NORMAL;
                        emit_code_point(21'h10000 + {high_bits, hex_acc[9:0]});
                    end
                end
            end
            default: first_fault = ST_MALFORMED;
        endcase
    endtask

    task automatic clear_string();
        parse_phase = PH_NORMAL;
        hex_acc = 16'h0;
        high_bits = 10'h0;
        bytes_out = 0;
        first_fault = ST_OK;
    endtask

    // Expected results of one accepted request.
    task automatic predict_request(logic [7:0] b, logic has, logic last);
        if (has && first_fault == ST_OK) decode_byte(b);
        if (last) begin
            if (first_fault == ST_OK && parse_phase != PH_NORMAL)
                first_fault = ST_MALFORMED;
            else if (first_fault == ST_OK && bytes_out + 1 > capacity)
                first_fault = ST_TOO_SMALL;
            pending_bytes.push_back('{8'h00, 1'b0, 1'b1, first_fault, bytes_out[15:0]});
            clear_string();
        end
    endtask

    // Offers one request after a random gap and waits until it is taken.
    task automatic send_request(logic [7:0] b, logic has, logic last, logic typed,
                                status_t st, logic [15:0] len);
        int r;
        int gap;
        gap = 0;
        if (!no_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(8, 30);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_byte <= b;
        has_byte <= has;
        end_of_string <= last;
        do @(posedge clk); while (full);
        predict_request(b, has, last);
        if (typed) begin
            void'(pending_bytes.pop_back());
            pending_bytes.push_back('{8'h00, 1'b0, 1'b1, st, len});
        end
        if (has || last) item_count++;
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        send_request(b, 1'b1, last, 1'b0, ST_OK, 16'd0);
    endtask

    // Waits for every expected result, then lets the block go quiet.
    task automatic drain();
        push <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_capacity(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPACITY_ADDR;
        pwdata <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        capacity = value;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return "0" + n;
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    task automatic append_unicode(logic [15:0] v);
        body.push_back(BACKSLASH);
        body.push_back(U_LETTER);
        for (int i = 3; i >= 0; i--) body.push_back(hex_char(v[4*i +: 4]));
    endtask

    // A BMP code point outside the surrogates, spread over the 1-, 2- and 3-byte UTF-8 lengths.
    function automatic logic [15:0] pick_bmp();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'h007F;
                2: return 16'h0080;
                3: return 16'h07FF;
                4: return 16'h0800;
                default: return 16'hFFFF;
            endcase
        end
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    // Mostly well-formed escapes with random content, some broken ones.
    task automatic append_token();
        logic [7:0] letters [8];
        int r;
        letters = '{QUOTE, BACKSLASH, SLASH, "b", "f", "n", "r", "t"};
        r = $urandom_range(0, 99);
        if (r < 40) begin
            body.push_back(8'($urandom_range(0, 255)));
            if (body[$] == BACKSLASH) body[$] = 8'h5B;
        end
        else if (r < 60) begin
            body.push_back(BACKSLASH);
            body.push_back(letters[$urandom_range(0, 7)]);
        end
        else if (r < 75) begin
            append_unicode(pick_bmp());
        end
        else if (r < 85) begin
            append_unicode(HI_SURR_MIN + 16'($urandom_range(0, 16'h3FF)));
            append_unicode(LO_SURR_MIN + 16'($urandom_range(0, 16'h3FF)));
        end
        else begin
            case ($urandom_range(0, 4))
                0: begin
                    body.push_back(BACKSLASH);
                    body.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    body.push_back(BACKSLASH);
                    body.push_back(U_LETTER);
                    repeat (4) begin
                        if ($urandom_range(0, 3) == 0)
                            body.push_back(8'($urandom_range(0, 255)));
                        else
                            body.push_back(hex_char(4'($urandom_range(0, 15))));
                    end
                end
                2: append_unicode(LO_SURR_MIN + 16'($urandom_range(0, 16'h3FF)));
                3: begin
                    // A high surrogate with a bad or missing low half.
                    append_unicode(HI_SURR_MIN + 16'($urandom_range(0, 16'h3FF)));
                    case ($urandom_range(0, 2))
                        0: body.push_back(8'($urandom_range(0, 255)));
                        1: begin
                            body.push_back(BACKSLASH);
                            body.push_back(8'($urandom_range(0, 255)));
                        end
                        default: append_unicode(pick_bmp());
                    endcase
                end
                default: body.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // One random string, closed either on its last byte or by an end-only request.
    task automatic run_string();
        int tokens;
        bit close_on_byte;
        tokens = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
        body.delete();
        repeat (tokens) append_token();
        if ($urandom_range(0, 19) == 0) begin
            body.push_back(BACKSLASH);
            if ($urandom_range(0, 1)) begin
                body.push_back(U_LETTER);
                body.push_back(hex_char(4'($urandom_range(0, 15))));
            end
        end
        no_gaps = ($urandom_range(0, 3) == 0);
        close_on_byte = (body.size() > 0) && ($urandom_range(0, 2) == 0);
        foreach (body[i]) begin
            if ($urandom_range(0, 19) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, ST_OK, 16'd0);
            send_byte(body[i], close_on_byte && (i == body.size() - 1));
        end
        if (!close_on_byte)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, ST_OK, 16'd0);
    endtask

    // Result side: random pop runs and stalls, each result checked in order.
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n) begin
            if (pop && !empty) begin
                if (pending_bytes.size() == 0) begin
                    $display("%0t: unexpected result byte=%02h done=%b", $time,
                             out_byte, string_done);
                    fail_count++;
                end
                else begin
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.data) begin
                        $display("%0t: out_byte expected %02h actual %02h", $time,
                                 want.data, out_byte);
                        fail_count++;
                    end
                    if (byte_valid !== want.valid) begin
                        $display("%0t: byte_valid expected %b actual %b", $time,
                                 want.valid, byte_valid);
                        fail_count++;
                    end
                    if (string_done !== want.done) begin
                        $display("%0t: string_done expected %b actual %b", $time,
                                 want.done, string_done);
                        fail_count++;
                    end
                    if (status !== want.st) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.st, status);
                        fail_count++;
                    end
                    if (total_length !== want.len) begin
                        $display("%0t: total_length expected %0d actual %0d", $time,
                                 want.len, total_length);
                        fail_count++;
                    end
                end
            end
            if (pop_run == 0) begin
                pop_level = ($urandom_range(0, 99) < 65);
                if (pop_level)
                    pop_run = $urandom_range(1, 30);
                else if ($urandom_range(0, 9) == 0)
                    pop_run = $urandom_range(10, 40);
                else
                    pop_run = $urandom_range(1, 3);
            end
            pop_run--;
            pop <= pop_level;
        end
    end

    // Watchdog on cycles with no request and no result moving.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty) || psel) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("json_string_unescape_utf8_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int start_count;
        logic [15:0] settings [6];
        settings = '{16'd1, 16'd0, 16'd24, 16'd65535, 16'd9, 16'd0};
        settings[5] = 16'($urandom_range(2, 60));
        capacity = CAPACITY_RESET;
        clear_string();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run at the reset capacity.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i].data, DIRECTED[i].has, DIRECTED[i].last,
                         DIRECTED[i].typed, DIRECTED[i].st, DIRECTED[i].len);
        drain();

        // Random strings under each capacity setting.
        foreach (settings[p]) begin
            write_capacity(settings[p]);
            start_count = item_count;
            while (item_count - start_count < PHASE_ITEMS) run_string();
            drain();
        end

        if (fail_count == 0)
            $display("json_string_unescape_utf8_core verification clean");
        else
            $display("json_string_unescape_utf8_core verification failed");
        $finish;
    end

endmodule
